// ----- design/mfa_pkg.sv -----
// Package with the field constants and operation codes of the Montgomery field unit.
package mfa_pkg;
	localparam int unsigned FW = 256;

	localparam logic [FW-1:0] MODQ = {64'd8353516859464449352, 64'd3691218898639771653,
		64'd6034159408538082302, 64'd18446744069414584321};

	localparam logic [FW-1:0] MONT_ONE = {64'd1739710354780652911,
		64'd11064306276430008309, 64'd6378425256633387010, 64'd8589934590};

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_NEG = 3'd2;
	localparam logic [2:0] OP_MUL = 3'd3;
	localparam logic [2:0] OP_SQR = 3'd4;
	localparam logic [2:0] OP_POW = 3'd5;

	typedef logic [FW-1:0] fe_t;
endpackage

// ----- design/montgomery_field_alu_256.sv -----
// Top level of the Montgomery field unit for the BLS12-381 scalar prime.
// A word is taken when start is high and busy is low; its result appears on r_limb0..r_limb3
// for exactly one cycle with done high, and the receiver cannot stall it. Add and subtract
// pass through states S_ALU1 and S_ALU2; negate and the unused codes finish in S_ALU1.
// Multiply and square run a radix-2 Montgomery loop, one multiplier bit a cycle. Power
// performs up to 512 such products, all bound by that one loop.
module montgomery_field_alu_256 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [63:0] a_limb0,
	input  logic [63:0] a_limb1,
	input  logic [63:0] a_limb2,
	input  logic [63:0] a_limb3,
	input  logic [63:0] b_limb0,
	input  logic [63:0] b_limb1,
	input  logic [63:0] b_limb2,
	input  logic [63:0] b_limb3,
	output logic        done,
	output logic [63:0] r_limb0,
	output logic [63:0] r_limb1,
	output logic [63:0] r_limb2,
	output logic [63:0] r_limb3
);
	import mfa_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ALU1  = 3'd1;
	localparam logic [2:0] S_ALU2  = 3'd2;
	localparam logic [2:0] S_MINIT = 3'd3;
	localparam logic [2:0] S_MLOOP = 3'd4;
	localparam logic [2:0] S_MFIN  = 3'd5;
	localparam logic [2:0] S_PSTEP = 3'd6;

	logic [2:0]   state_q;
	logic [2:0]   op_q;
	fe_t          a_q, b_q, acc_q, mx_q, my_q, r_q;
	logic [FW:0]  myq_q, t_q;
	logic [7:0]   cnt_q, ecnt_q;
	logic         dest_q, done_q;

	logic         m_bit;
	logic [FW:0]  addend;
	logic [FW+1:0] msum;
	fe_t          mres;
	logic [FW:0]  add_s, sub_s;

	always_comb begin
		m_bit = t_q[0] ^ (mx_q[0] & my_q[0]);
		case ({mx_q[0], m_bit})
			2'b00: addend = '0;
			2'b01: addend = {1'b0, MODQ};
			2'b10: addend = {1'b0, my_q};
			default: addend = myq_q;
		endcase
		msum = {1'b0, t_q} + {1'b0, addend};
		if (t_q[FW] || t_q[FW-1:0] >= MODQ) begin
			mres = t_q[FW-1:0] - MODQ;
		end else begin
			mres = t_q[FW-1:0];
		end
		add_s = {1'b0, a_q} + {1'b0, b_q};
		sub_s = {1'b0, a_q} - {1'b0, b_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q <= action;
						a_q  <= {a_limb3, a_limb2, a_limb1, a_limb0};
						b_q  <= {b_limb3, b_limb2, b_limb1, b_limb0};
						mx_q <= {a_limb3, a_limb2, a_limb1, a_limb0};
						if (action == OP_MUL) begin
							my_q    <= {b_limb3, b_limb2, b_limb1, b_limb0};
							state_q <= S_MINIT;
						end else if (action == OP_SQR) begin
							my_q    <= {a_limb3, a_limb2, a_limb1, a_limb0};
							state_q <= S_MINIT;
						end else if (action == OP_POW) begin
							acc_q   <= MONT_ONE;
							ecnt_q  <= '0;
							state_q <= S_PSTEP;
						end else begin
							state_q <= S_ALU1;
						end
					end
				end
				S_ALU1: begin
					case (op_q)
						OP_ADD: begin
							t_q     <= add_s;
							state_q <= S_ALU2;
						end
						OP_SUB: begin
							t_q     <= sub_s;
							state_q <= S_ALU2;
						end
						OP_NEG: begin
							r_q     <= MODQ - a_q;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						default: begin
							r_q     <= '0;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_ALU2: begin
					if (op_q == OP_ADD) begin
						r_q <= mres;
					end else if (t_q[FW]) begin
						r_q <= t_q[FW-1:0] + MODQ;
					end else begin
						r_q <= t_q[FW-1:0];
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_PSTEP: begin
					if (b_q[0]) begin
						mx_q   <= acc_q;
						my_q   <= a_q;
						dest_q <= 1'b0;
					end else begin
						mx_q   <= a_q;
						my_q   <= a_q;
						dest_q <= 1'b1;
					end
					state_q <= S_MINIT;
				end
				S_MINIT: begin
					myq_q   <= {1'b0, my_q} + {1'b0, MODQ};
					t_q     <= '0;
					cnt_q   <= '0;
					state_q <= S_MLOOP;
				end
				S_MLOOP: begin
					t_q   <= msum[FW+1:1];
					mx_q  <= mx_q >> 1;
					cnt_q <= cnt_q + 8'd1;
					if (cnt_q == 8'hff) begin
						state_q <= S_MFIN;
					end
				end
				S_MFIN: begin
					if (op_q != OP_POW) begin
						r_q     <= mres;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (!dest_q) begin
						acc_q   <= mres;
						mx_q    <= a_q;
						my_q    <= a_q;
						dest_q  <= 1'b1;
						state_q <= S_MINIT;
					end else begin
						a_q    <= mres;
						b_q    <= b_q >> 1;
						ecnt_q <= ecnt_q + 8'd1;
						if (ecnt_q == 8'hff) begin
							r_q     <= acc_q;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_PSTEP;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign r_limb0 = r_q[63:0];
	assign r_limb1 = r_q[127:64];
	assign r_limb2 = r_q[191:128];
	assign r_limb3 = r_q[255:192];
endmodule

// ----- sim/montgomery_field_alu_256_tb.sv -----
// Self-checking testbench for the BLS12-381 scalar field arithmetic unit.
module montgomery_field_alu_256_tb;
	import mfa_pkg::*;

	localparam logic [63:0] MONT_INV = 64'd18446744069414584319;
	localparam logic [2:0]  OP_SPARE6 = 3'd6;
	localparam logic [2:0]  OP_SPARE7 = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic [2:0]  action;
	logic [63:0] a_limb0, a_limb1, a_limb2, a_limb3;
	logic [63:0] b_limb0, b_limb1, b_limb2, b_limb3;
	logic        busy, done;
	logic [63:0] r_limb0, r_limb1, r_limb2, r_limb3;

	fe_t pending_results[$];
	int  error_count = 0;
	int  idle_pct = 0;

	montgomery_field_alu_256 i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.a_limb0(a_limb0), .a_limb1(a_limb1), .a_limb2(a_limb2), .a_limb3(a_limb3),
		.b_limb0(b_limb0), .b_limb1(b_limb1), .b_limb2(b_limb2), .b_limb3(b_limb3),
		.done(done), .r_limb0(r_limb0), .r_limb1(r_limb1), .r_limb2(r_limb2),
		.r_limb3(r_limb3)
	);

	always #2 clk = ~clk;

	function automatic fe_t mont_product(fe_t x, fe_t y);
		logic [576:0] acc;
		logic [63:0]  m;
		fe_t          low;
		acc = 577'(x) * 577'(y);
		for (int i = 0; i < 4; i++) begin
			m = acc[64*i +: 64] * MONT_INV;
			acc = acc + ((577'(m) * 577'(MODQ)) << (64 * i));
		end
		low = acc[511:256];
		if (acc[576:512] != 0 || low >= MODQ) begin
			low = low - MODQ;
		end
		return low;
	endfunction

	function automatic fe_t field_result(logic [2:0] op, fe_t a, fe_t b);
		logic [256:0] sum;
		fe_t          r, acc, base;
		case (op)
			OP_ADD: begin
				sum = {1'b0, a} + {1'b0, b};
				r = sum[255:0];
				if (sum >= {1'b0, MODQ}) begin
					r = r - MODQ;
				end
			end
			OP_SUB: begin
				r = a - b;
				if (a < b) begin
					r = r + MODQ;
				end
			end
			OP_NEG: r = MODQ - a;
			OP_MUL: r = mont_product(a, b);
			OP_SQR: r = mont_product(a, a);
			OP_POW: begin
				acc = MONT_ONE;
				base = a;
				for (int i = 0; i < 256; i++) begin
					if (b[i]) begin
						acc = mont_product(acc, base);
					end
					base = mont_product(base, base);
				end
				r = acc;
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic fe_t rand_fe();
		fe_t v;
		v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = MODQ - 1;
			2: v = MODQ;
			3: v = '1;
			4: v = MONT_ONE;
			5: ;
			default: v[255:254] = 2'b00;
		endcase
		return v;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		error_count++;
	endtask

	task automatic send_word(logic [2:0] op, fe_t a, fe_t b);
		if ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		action = op;
		{a_limb3, a_limb2, a_limb1, a_limb0} = a;
		{b_limb3, b_limb2, b_limb1, b_limb0} = b;
		start = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		pending_results.push_back(field_result(op, a, b));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", r_limb0, 64'd0);
			end else begin
				fe_t want;
				want = pending_results.pop_front();
				if (r_limb0 !== want[63:0]) report_mismatch("r_limb0", r_limb0, want[63:0]);
				if (r_limb1 !== want[127:64]) report_mismatch("r_limb1", r_limb1, want[127:64]);
				if (r_limb2 !== want[191:128]) report_mismatch("r_limb2", r_limb2, want[191:128]);
				if (r_limb3 !== want[255:192]) report_mismatch("r_limb3", r_limb3, want[255:192]);
			end
		end
	end

	task automatic test_linear_edges();
		send_word(OP_ADD, MODQ - 1, MODQ - 1);
		send_word(OP_ADD, '1, '1);
		send_word(OP_ADD, '0, '0);
		send_word(OP_ADD, MODQ - 1, 256'd1);
		send_word(OP_SUB, '0, MODQ - 1);
		send_word(OP_SUB, MODQ, MODQ);
		send_word(OP_SUB, '0, '1);
		send_word(OP_NEG, '0, '1);
		send_word(OP_NEG, '1, '0);
		send_word(OP_NEG, MODQ - 1, '0);
	endtask

	task automatic test_product_edges();
		send_word(OP_MUL, '1, '1);
		send_word(OP_MUL, MODQ - 1, MODQ - 1);
		send_word(OP_MUL, MONT_ONE, MODQ - 1);
		send_word(OP_MUL, '0, '1);
		send_word(OP_SQR, '1, '0);
		send_word(OP_SQR, MODQ, '1);
	endtask

	task automatic test_unused_codes();
		send_word(OP_SPARE6, '1, '1);
		send_word(OP_SPARE7, MODQ, MONT_ONE);
	endtask

	task automatic test_power();
		send_word(OP_POW, MONT_ONE, '0);
		send_word(OP_POW, MODQ - 1, '1);
		send_word(OP_POW, rand_fe(), rand_fe());
		wait_drained();
	endtask

	task automatic test_random(int pct, int count);
		logic [2:0] op;
		idle_pct = pct;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: op = OP_ADD;
				5, 6, 7, 8, 9: op = OP_SUB;
				10, 11, 12: op = OP_NEG;
				13, 14: op = OP_MUL;
				15, 16: op = OP_SQR;
				17: op = OP_SPARE6;
				18: op = OP_SPARE7;
				default: op = OP_MUL;
			endcase
			send_word(op, rand_fe(), rand_fe());
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		action = OP_ADD;
		{a_limb3, a_limb2, a_limb1, a_limb0} = '0;
		{b_limb3, b_limb2, b_limb1, b_limb0} = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_linear_edges();
		test_product_edges();
		test_unused_codes();
		test_power();
		test_random(26, 420);
		test_random(73, 420);
		test_random(0, 410);
		wait_drained();
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#16000000;
		$display("Regression FAIL");
		$finish;
	end
endmodule

// ----- sim.f -----
design/mfa_pkg.sv
design/montgomery_field_alu_256.sv
sim/montgomery_field_alu_256_tb.sv
